[design/brf_pkg.sv]
// Shared constants and codes for the byte ring FIFO.
// No dependencies; imported by brf_ram and byte_ring_fifo_unit.
`default_nettype none

package brf_pkg;

    localparam int DEPTH_DEF     = 256;  // storage slots built
    localparam int MAX_BURST_DEF = 64;   // most bytes one get may return
    localparam int DATA_W        = 8;    // width of one stored byte
    localparam int CFG_W         = 9;    // width of the length register
    localparam int CNT_W         = 8;    // width of reported counts
    localparam int GET_W         = 7;    // width of the get count field
    localparam int MIN_LEN       = 2;    // shortest usable ring

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

endpackage

`default_nettype wire

[design/brf_ram.sv]
// Single-port-write, single-port-read byte store with registered read data.
// Depends on brf_pkg for the data width.
`default_nettype none

module brf_ram
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/byte_ring_fifo_unit.sv]
// Byte ring FIFO top level: request decode, index control, result register.
// Depends on brf_pkg and brf_ram.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tuser: op; tdata: data_in, get_count
// m_       out  m_tvalid/m_tready    tuser: valid_res; tdata: data_out, used, free; tlast
// cfg_     in   cfg_valid/cfg_ready  cfg_data: ring_length
//
// Put, flush and unused codes each give one result; a put may follow a put every cycle while m_tready is high.
// A get of n bytes first issues a read of the registered byte store, then returns one byte
// per cycle while the output is not held; an empty get gives a single result.
// Reset clears indices and sets the length to DEPTH; the store is not cleared.
// m_tready low holds the result and pauses a running get; no request is taken during a get.
`default_nettype none

module byte_ring_fifo_unit
    import brf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [7:0] data_in, [14:8] get_count, [15] zero
    input  wire logic [1:0]       s_tuser,   // [1:0] op

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [23:0]      m_tdata,   // [7:0] data_out, [15:8] used_count, [23:16] free_count
    output logic      [0:0]       m_tuser,   // [0] valid_res
    output logic                  m_tlast,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int IW  = $clog2(DEPTH);
    localparam int LW0 = $clog2(DEPTH + 1);
    localparam int LW  = (LW0 > CFG_W) ? LW0 : CFG_W;
    localparam int RW  = $clog2(MAX_BURST + 1);

    typedef enum logic {S_IDLE, S_GET} state_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              valid_res;
        logic              last;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free;
    } res_t;

    function automatic logic [LW-1:0] used_of(input logic [IW-1:0] w, input logic [IW-1:0] r,
                                              input logic [LW-1:0] len);
        logic [LW-1:0] wl;
        logic [LW-1:0] rl;
        wl = LW'(w);
        rl = LW'(r);
        if (wl >= rl) begin
            return wl - rl;
        end
        return (len - rl) + wl;
    endfunction

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] t;
        t = LW'(idx) + LW'(1);
        if (t >= len) begin
            return '0;
        end
        return IW'(t);
    endfunction

    state_t        state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          m_valid_reg;
    res_t          res_reg, res_next;

    logic              out_free, in_fire, cfg_fire, load;
    logic [LW-1:0]     used_cur, free_cur, used_nx, free_nx, want, n_get, cfg_len;
    logic              ram_wr_en, ram_rd_en;
    logic [IW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    op_t               op;

    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && out_free && !cfg_valid;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign op        = op_t'(s_tuser);

    assign used_cur = used_of(wr_idx_reg, rd_idx_reg, len_reg);
    assign free_cur = len_reg - used_cur - LW'(1);
    assign want     = (LW'(s_tdata[14:8]) > LW'(MAX_BURST)) ? LW'(MAX_BURST)
                                                            : LW'(s_tdata[14:8]);
    assign n_get    = (used_cur < want) ? used_cur : want;

    always_comb begin
        cfg_len = LW'(cfg_data);
        if (cfg_len < LW'(MIN_LEN)) begin
            cfg_len = LW'(MIN_LEN);
        end else if (cfg_len > LW'(DEPTH)) begin
            cfg_len = LW'(DEPTH);
        end
    end

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        rem_next    = rem_reg;
        load        = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_idx_reg;
        res_next    = '0;
        res_next.last = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (cfg_fire) begin
                    // a new length empties the ring
                    len_next    = cfg_len;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                end else if (in_fire) begin
                    case (op)
                        OP_PUT: begin
                            load = 1'b1;
                            if (free_cur != '0) begin
                                ram_wr_en          = 1'b1;
                                wr_idx_next        = next_idx(wr_idx_reg, len_reg);
                                res_next.valid_res = 1'b1;
                            end
                        end
                        OP_GET: begin
                            if (n_get == '0) begin
                                load = 1'b1;
                            end else begin
                                ram_rd_en  = 1'b1;
                                rem_next   = RW'(n_get);
                                state_next = S_GET;
                            end
                        end
                        OP_FLUSH: begin
                            load               = 1'b1;
                            rd_idx_next        = wr_idx_reg;
                            res_next.valid_res = 1'b1;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_GET: begin
                if (out_free) begin
                    load               = 1'b1;
                    res_next.data_out  = ram_rd_data;
                    res_next.valid_res = 1'b1;
                    res_next.last      = (rem_reg == RW'(1));
                    rd_idx_next        = next_idx(rd_idx_reg, len_reg);
                    rem_next           = rem_reg - RW'(1);
                    if (rem_reg == RW'(1)) begin
                        state_next = S_IDLE;
                    end else begin
                        // fetch the following byte while this one goes out
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_idx_next;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        used_nx       = used_of(wr_idx_next, rd_idx_next, len_reg);
        free_nx       = len_reg - used_nx - LW'(1);
        res_next.used = used_nx[CNT_W-1:0];
        res_next.free = free_nx[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= LW'(DEPTH);
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            rem_reg    <= rem_next;
            if (load) begin
                m_valid_reg <= 1'b1;
                res_reg     <= res_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    brf_ram #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (s_tdata[DATA_W-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {res_reg.free, res_reg.used, res_reg.data_out};
    assign m_tuser[0] = res_reg.valid_res;
    assign m_tlast    = res_reg.last;

`ifndef ASSERT_OFF
    a_idx_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (LW'(rd_idx_reg) < len_reg) && (LW'(wr_idx_reg) < len_reg))
        else $error("ring index beyond length");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_cur < len_reg)
        else $error("used count reaches ring length");

    a_get_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GET) |-> (rem_reg != '0))
        else $error("get running with nothing left");

    a_get_holds_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GET) |=> $stable(wr_idx_reg) && $stable(len_reg))
        else $error("write side moved during a get");

    a_get_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GET && out_free && rem_reg == RW'(1))
        |=> (state_reg == S_IDLE) && m_tvalid && m_tlast)
        else $error("get did not finish on its last byte");
`endif

endmodule

`default_nettype wire
